// File: hw/rtl/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, constants and saturating helpers for the carrier drift step.
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int POSITIONS = 512;
  localparam int FRAC_BITS = 48;
  localparam int CNT_W     = $clog2(POSITIONS + 1);
  localparam int IDX_W     = 9;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  localparam logic [2:0] REG_TS    = 3'd0;
  localparam logic [2:0] REG_DX    = 3'd1;
  localparam logic [2:0] REG_DONOR = 3'd2;
  localparam logic [2:0] REG_ACC   = 3'd3;
  localparam logic [2:0] REG_JUNC  = 3'd4;

  // multiplier operation select
  typedef enum logic [1:0] {
    MUL_Q48 = 2'd0,
    MUL_INT = 2'd1
  } mul_mode_t;

  typedef struct packed {
    logic        start;
    mul_mode_t   mode;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] y;
  } mul_rsp_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sat_add = s[64] ? S64_MIN : S64_MAX;
    else sat_add = s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) sat_sub = s[64] ? S64_MIN : S64_MAX;
    else sat_sub = s[63:0];
  endfunction

  // floor((a-b)/2) exactly
  function automatic logic [63:0] half_diff(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    half_diff = s[64:1];
  endfunction

  function automatic logic [63:0] half_sum(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    half_sum = s[64:1];
  endfunction

endpackage

// File: hw/rtl/cds_mul.sv
// ----------------------------------------------------------------------------
// cds_mul
// Shared signed 64x64 multiplier, one 32x32 partial product per cycle,
// Q16.48 rounding or integer mode, saturated to 64 bits.
// ----------------------------------------------------------------------------
module cds_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  cds_pkg::mul_req_t req,
  output cds_pkg::mul_rsp_t rsp
);
  import cds_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_P0, S_P1, S_P2, S_P3, S_FIN} st_t;

  st_t          st_r;
  logic [63:0]  ma_r, mb_r;
  logic         neg_r;
  mul_mode_t    mode_r;
  logic [127:0] acc_r;
  logic [63:0]  pp_r;
  logic [1:0]   sel_r;
  logic         pv_r;
  logic [63:0]  y_r;
  logic         done_r;

  logic [31:0]  opa, opb;
  logic [63:0]  pp;
  logic [127:0] pp_sh, acc_fin, rnd;
  logic [63:0]  limit;
  logic [63:0]  mag;
  logic [63:0]  y_nxt;

  always_comb begin
    opa = sel_r[0] ? ma_r[63:32] : ma_r[31:0];
    opb = sel_r[1] ? mb_r[63:32] : mb_r[31:0];
    pp  = opa * opb;
  end

  logic [1:0] psel_r;
  always_comb begin
    pp_sh   = {64'd0, pp_r} << (7'd32 * (7'(psel_r[0]) + 7'(psel_r[1])));
    acc_fin = acc_r + (pv_r ? pp_sh : 128'd0);
    rnd     = (mode_r == MUL_Q48) ? ((acc_fin + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS)
                                  : acc_fin;
    limit   = neg_r ? S64_MIN : S64_MAX;
    mag     = rnd[63:0];
    if (rnd[127:64] != 64'd0 || rnd[63:0] > limit) y_nxt = neg_r ? S64_MIN : S64_MAX;
    else y_nxt = neg_r ? (64'd0 - mag) : mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
      pv_r   <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          done_r <= 1'b0;
          if (req.start) begin
            ma_r   <= req.a[63] ? 64'd0 - req.a : req.a;
            mb_r   <= req.b[63] ? 64'd0 - req.b : req.b;
            neg_r  <= req.a[63] ^ req.b[63];
            mode_r <= req.mode;
            acc_r  <= 128'd0;
            sel_r  <= 2'd0;
            pv_r   <= 1'b0;
            st_r   <= S_P0;
          end
        end
        S_P0, S_P1, S_P2, S_P3: begin
          acc_r  <= acc_fin;
          pp_r   <= pp;
          psel_r <= sel_r;
          pv_r   <= 1'b1;
          sel_r  <= sel_r + 2'd1;
          case (st_r)
            S_P0:    st_r <= S_P1;
            S_P1:    st_r <= S_P2;
            S_P2:    st_r <= S_P3;
            default: st_r <= S_FIN;
          endcase
        end
        S_FIN: begin
          y_r    <= y_nxt;
          done_r <= 1'b1;
          pv_r   <= 1'b0;
          st_r   <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.y    = y_r;

  a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_FIN |=> done_r) else $error("multiplier result missing");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("multiplier done held");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> st_r == S_IDLE) else $error("multiplier busy at done");

endmodule

// File: hw/rtl/carrier_drift_step.sv
// ----------------------------------------------------------------------------
// carrier_drift_step
// One explicit time step of electron and hole densities along a 1D grid.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)                    | tuser/tlast
//  in_     | in  | electron_density[63:0], hole_density[127:64] | tlast=last_position
//  out_    | out | position_index[8:0], next_e[72:9],           | tlast=row_done
//          |     | next_h[136:73], field_times_spacing[200:137] |
//  cfg_    | in  | index 3 bits, data 64 bits                   |
//
// each result runs eight multiplies on the shared unit (nine right of the
// junction), then the field step and the output load; the last position of
// a row adds its flush result.
// in_tready is low while a position is in work.
// reset restores the register defaults and starts a new row; out_ stalls hold
// the sequencer until the pending result is taken.
module carrier_drift_step (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // electron_density, hole_density
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [207:0] out_tdata,  // position_index, next e, next h, field*dx, zero pad
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import cds_pkg::*;

  typedef enum logic [3:0] {
    S_IN, S_A1, S_A2, S_E, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_OUT
  } st_t;

  st_t          st_r;
  logic [62:0]  ts_r, dx_r, donor_r, acc_r;
  logic [9:0]   junc_r;
  logic [63:0]  pe_r, ph_r, ce_r, ch_r, fe_r, fh_r, q_r;
  logic [CNT_W-1:0] seen_r;
  logic [63:0]  ne_r, nh_r;      // next-neighbour values
  logic [IDX_W-1:0] j_r;
  logic [15:0]  jw_r;
  logic         done_r, flush_r;
  logic [63:0]  atoms_r, e_r, t1_r, t2_r, t3_r, r_r, dn_r, dp_r;
  logic [63:0]  oe_r, oh_r, of_r;
  logic         ov_r, ol_r;
  logic [IDX_W-1:0] oj_r;

  mul_req_t req;
  mul_rsp_t rsp;

  cds_mul u_mul (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  logic mul_busy_r;
  logic go;
  logic [16:0] jk;
  logic        left;

  assign jk   = {1'b0, jw_r} - {7'd0, junc_r};
  assign left = jk[16];

  assign in_tready  = (st_r == S_IN);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tlast  = ol_r;
  assign out_tdata  = {7'd0, of_r, oh_r, oe_r, oj_r};

  // operand mux for the shared multiplier
  always_comb begin
    req = '0;
    req.start = go;
    req.mode  = MUL_Q48;
    case (st_r)
      S_A1: begin
        req.mode = MUL_INT;
        req.a = {1'b0, donor_r};
        req.b = left ? {48'd0, jw_r} : {{54{1'b0}}, junc_r} - 64'd1;
      end
      S_A2: begin
        req.mode = MUL_INT;
        req.a = {1'b0, acc_r};
        req.b = {{47{jk[16]}}, jk};
      end
      S_M1: begin req.a = dn_r; req.b = e_r; end
      S_M2: begin req.a = r_r;  req.b = ce_r; end
      S_M3: begin req.a = {1'b0, ts_r}; req.b = t1_r; end
      S_M4: begin req.a = dp_r; req.b = e_r; end
      S_M5: begin req.a = r_r;  req.b = ch_r; end
      S_M6: begin req.a = {1'b0, ts_r}; req.b = t1_r; end
      S_M7: begin req.a = e_r;  req.b = {1'b0, dx_r}; end
      default: ;
    endcase
  end

  assign go = !mul_busy_r && (st_r != S_IN) && (st_r != S_E) && (st_r != S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IN;
      seen_r     <= '0;
      ov_r       <= 1'b0;
      mul_busy_r <= 1'b0;
      ts_r       <= 63'd28147497671066;
      dx_r       <= 63'd562949953421;
      donor_r    <= 63'd28147497671;
      acc_r      <= 63'd28147497671;
      junc_r     <= 10'd250;
      pe_r <= '0; ph_r <= '0; ce_r <= '0; ch_r <= '0;
      fe_r <= '0; fh_r <= '0; q_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_TS:    ts_r    <= cfg_data[62:0];
          REG_DX:    dx_r    <= cfg_data[62:0];
          REG_DONOR: donor_r <= cfg_data[62:0];
          REG_ACC:   acc_r   <= cfg_data[62:0];
          REG_JUNC:  junc_r  <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (ov_r && out_tready) ov_r <= 1'b0;
      if (go) mul_busy_r <= 1'b1;
      if (rsp.done) mul_busy_r <= 1'b0;

      case (st_r)
        S_IN: begin
          if (in_tvalid && in_tready) begin
            if (seen_r == '0) begin
              fe_r <= in_tdata[63:0];  fh_r <= in_tdata[127:64];
              pe_r <= in_tdata[63:0];  ph_r <= in_tdata[127:64];
              ce_r <= in_tdata[63:0];  ch_r <= in_tdata[127:64];
              q_r  <= sat_sub(in_tdata[63:0], in_tdata[127:64]);
              if (in_tlast || seen_r + 1'b1 >= CNT_W'(POSITIONS)) begin
                ne_r <= in_tdata[63:0]; nh_r <= in_tdata[127:64];
                j_r <= '0; jw_r <= '0; done_r <= 1'b1; flush_r <= 1'b0;
                seen_r <= '0;
                st_r <= S_A1;
              end else seen_r <= seen_r + 1'b1;
            end else begin
              ne_r <= in_tdata[63:0]; nh_r <= in_tdata[127:64];
              j_r  <= IDX_W'(seen_r - 1'b1);
              jw_r <= 16'(seen_r - 1'b1);
              done_r  <= 1'b0;
              flush_r <= in_tlast || (seen_r + 1'b1 >= CNT_W'(POSITIONS));
              seen_r  <= (in_tlast || (seen_r + 1'b1 >= CNT_W'(POSITIONS))) ?
                         '0 : seen_r + 1'b1;
              st_r <= S_A1;
            end
          end
        end
        S_A1: if (rsp.done) begin
          atoms_r <= rsp.y;
          dn_r <= half_diff(ne_r, pe_r);
          dp_r <= half_diff(nh_r, ph_r);
          r_r  <= sat_sub(ch_r, ce_r);
          st_r <= left ? S_E : S_A2;
        end
        S_A2: if (rsp.done) begin
          atoms_r <= sat_sub(atoms_r, rsp.y);
          st_r <= S_E;
        end
        S_E: begin
          e_r  <= sat_add(sat_add(half_sum(sat_sub(fh_r, fe_r), r_r), q_r), atoms_r);
          st_r <= S_M1;
        end
        S_M1: if (rsp.done) begin t1_r <= rsp.y; st_r <= S_M2; end
        S_M2: if (rsp.done) begin t1_r <= sat_add(t1_r, rsp.y); st_r <= S_M3; end
        S_M3: if (rsp.done) begin t2_r <= sat_add(ce_r, rsp.y); st_r <= S_M4; end
        S_M4: if (rsp.done) begin t1_r <= rsp.y; st_r <= S_M5; end
        S_M5: if (rsp.done) begin t1_r <= sat_add(t1_r, rsp.y); st_r <= S_M6; end
        S_M6: if (rsp.done) begin t3_r <= sat_sub(ch_r, rsp.y); st_r <= S_M7; end
        S_M7: if (rsp.done) begin t1_r <= rsp.y; st_r <= S_OUT; end
        S_OUT: begin
          if (!ov_r) begin
            ov_r <= 1'b1; oe_r <= t2_r; oh_r <= t3_r; of_r <= t1_r;
            oj_r <= j_r; ol_r <= done_r;
            if (done_r) begin
              st_r <= S_IN;
            end else begin
              // shift the window after a regular result
              q_r  <= sat_add(q_r, sat_sub(ch_r, ce_r));
              pe_r <= ce_r; ph_r <= ch_r;
              ce_r <= ne_r; ch_r <= nh_r;
              if (flush_r) begin
                ne_r <= ne_r; nh_r <= nh_r;
                j_r  <= j_r + 1'b1; jw_r <= jw_r + 16'd1;
                done_r <= 1'b1; seen_r <= '0;
                st_r <= S_A1;
              end else st_r <= S_IN;
            end
          end
        end
        default: st_r <= S_IN;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IN |-> !in_tready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_tready |=> ov_r) else $error("result dropped");
  a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r < CNT_W'(POSITIONS)) else $error("row count overrun");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// carrier_drift_step testbench
// Streams rows of electron and hole densities through the block, predicts
// every updated position with a local fixed-point model and checks each
// result field. Runs through several register settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import cds_pkg::*;

  localparam int  HALF_PERIOD = 5;
  localparam int  DRAIN_WAIT  = 300;
  localparam int  HOLD_CYCLES = 3000;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [63:0] ONE_Q48 = 64'h0001_0000_0000_0000;

  typedef struct packed {
    logic signed [63:0] electron;
    logic signed [63:0] hole;
    logic               last;
  } sample_t;

  typedef struct packed {
    logic [8:0]         index;
    logic signed [63:0] next_e;
    logic signed [63:0] next_h;
    logic signed [63:0] field_dx;
    logic               done;
  } position_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [207:0] out_tdata;
  logic         out_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  carrier_drift_step uut (.*);

  always #HALF_PERIOD clk = ~clk;

  // predictor copy of registers and row state
  logic [62:0]        step_scale, spacing, donor, acceptor;
  logic [9:0]         junction;
  logic signed [63:0] prev_e, prev_h, cent_e, cent_h, first_e, first_h, charge;
  int                 seen;

  sample_t          pending_samples[$];
  position_result_t expected_results[$];
  int  send_idle_pct = 0, recv_stall_pct = 0;
  bit  hold_off = 1'b0;
  bit  in_taken = 1'b0;
  int  failures = 0, results_checked = 0, rows_done = 0;
  longint cycles = 0;

  function automatic void enqueue_sample(input sample_t s);
    pending_samples = {pending_samples, s};
  endfunction

  function automatic void enqueue_result(input position_result_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic logic signed [63:0] clamp(input logic signed [64:0] s);
    if (s > $signed({1'b0, S64_MAX})) return S64_MAX;
    if (s < $signed({1'b1, S64_MIN})) return S64_MIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] plus(input logic signed [63:0] a, b);
    return clamp({a[63], a} + {b[63], b});
  endfunction

  function automatic logic signed [63:0] minus(input logic signed [63:0] a, b);
    return clamp({a[63], a} - {b[63], b});
  endfunction

  function automatic logic signed [63:0] floor_half(input logic signed [64:0] s);
    logic signed [64:0] h;
    h = s >>> 1;
    return h[63:0];
  endfunction

  // exact product, shifted with magnitude rounded half away from zero, saturated
  function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a, b,
                                                        input int sh);
    logic         neg;
    logic [63:0]  ma, mb;
    logic [127:0] pr, lim;
    neg = a[63] ^ b[63];
    ma  = a[63] ? -a : a;
    mb  = b[63] ? -b : b;
    pr  = {64'd0, ma} * {64'd0, mb};
    if (sh > 0) pr = (pr + (128'd1 << (sh - 1))) >> sh;
    lim = neg ? {64'd0, S64_MIN} : {64'd0, S64_MAX};
    if (pr > lim) return neg ? S64_MIN : S64_MAX;
    return neg ? -pr[63:0] : pr[63:0];
  endfunction

  function automatic position_result_t drift_update(input int j,
      input logic signed [63:0] ne_prev, nh_prev, ne_c, nh_c, ne_next, nh_next,
      input logic done);
    position_result_t   res;
    logic signed [63:0] dn, dp, r, atoms, e, nt, pt, jj, k;
    jj = j;
    k  = {54'd0, junction};
    dn = floor_half({ne_next[63], ne_next} - {ne_prev[63], ne_prev});
    dp = floor_half({nh_next[63], nh_next} - {nh_prev[63], nh_prev});
    r  = minus(nh_c, ne_c);
    if (jj < k) atoms = scaled_product({1'b0, donor}, jj, 0);
    else atoms = minus(scaled_product({1'b0, donor}, k - 1, 0),
                       scaled_product({1'b0, acceptor}, jj - k, 0));
    e = minus(first_h, first_e);
    e = floor_half({e[63], e} + {r[63], r});
    e = plus(plus(e, charge), atoms);
    nt = plus(scaled_product(dn, e, FRAC_BITS), scaled_product(r, ne_c, FRAC_BITS));
    pt = plus(scaled_product(dp, e, FRAC_BITS), scaled_product(r, nh_c, FRAC_BITS));
    res.index    = j[8:0];
    res.next_e   = plus(ne_c, scaled_product({1'b0, step_scale}, nt, FRAC_BITS));
    res.next_h   = minus(nh_c, scaled_product({1'b0, step_scale}, pt, FRAC_BITS));
    res.field_dx = scaled_product(e, {1'b0, spacing}, FRAC_BITS);
    res.done     = done;
    return res;
  endfunction

  function automatic void advance_row(input sample_t s);
    if (seen == 0) begin
      first_e = s.electron;
      first_h = s.hole;
      prev_e  = s.electron;
      cent_e  = s.electron;
      prev_h  = s.hole;
      cent_h  = s.hole;
      charge  = minus(s.electron, s.hole);
    end else begin
      enqueue_result(drift_update(seen - 1, prev_e, prev_h, cent_e, cent_h,
                                  s.electron, s.hole, 1'b0));
      charge = plus(charge, minus(cent_h, cent_e));
      prev_e = cent_e;
      prev_h = cent_h;
      cent_e = s.electron;
      cent_h = s.hole;
    end
    seen++;
    if (s.last || seen >= POSITIONS) begin
      enqueue_result(drift_update(seen - 1, prev_e, prev_h, cent_e, cent_h,
                                  cent_e, cent_h, 1'b1));
      seen = 0;
    end
  endfunction

  function automatic void apply_register(input logic [2:0] idx, input logic [63:0] val);
    case (idx)
      REG_TS:    step_scale = val[62:0];
      REG_DX:    spacing    = val[62:0];
      REG_DONOR: donor      = val[62:0];
      REG_ACC:   acceptor   = val[62:0];
      REG_JUNC:  junction   = val[9:0];
      default: ;
    endcase
  endfunction

  // input side: held until taken, then the next pending sample or a gap
  always @(posedge clk) in_taken <= in_tvalid && in_tready;

  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      if (rst_n && pending_samples.size() > 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        sample_t s;
        s = pending_samples.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {s.hole, s.electron};
        in_tlast  <= s.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench NOT OK");
      $finish;
    end else if (rst_n) begin
      if (in_tvalid && in_tready)
        advance_row('{in_tdata[63:0], in_tdata[127:64], in_tlast});
      if (out_tvalid && out_tready) begin
        position_result_t got, want;
        got = '{out_tdata[8:0], out_tdata[72:9], out_tdata[136:73], out_tdata[200:137],
                out_tlast};
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction at position %0d", got.index);
          failures++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (got.done) rows_done++;
          if (got.index !== want.index) begin
            $error("position_index: expected %0d, actual %0d", want.index, got.index);
            failures++;
          end
          if (got.next_e !== want.next_e) begin
            $error("next_electron_density: expected %h, actual %h", want.next_e, got.next_e);
            failures++;
          end
          if (got.next_h !== want.next_h) begin
            $error("next_hole_density: expected %h, actual %h", want.next_h, got.next_h);
            failures++;
          end
          if (got.field_dx !== want.field_dx) begin
            $error("field_times_spacing: expected %h, actual %h", want.field_dx,
                   got.field_dx);
            failures++;
          end
          if (got.done !== want.done) begin
            $error("row_done: expected %0d, actual %0d", want.done, got.done);
            failures++;
          end
        end
      end
    end
  end

  task automatic write_register(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [63:0] random_density();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1:    return r;
      2:       return $urandom_range(0, 1) ? S64_MAX : S64_MIN;
      default: return {{13{r[50]}}, r[50:0]};
    endcase
  endfunction

  function automatic void queue_rows(input int count);
    int left;
    left = count;
    while (left > 0) begin
      int len;
      len = $urandom_range(1, 20);
      if (len > left) len = left;
      for (int i = 0; i < len; i++)
        enqueue_sample('{random_density(), random_density(),
            // mostly clean rows, a few broken by a stray last mark
            (i == len - 1) || ($urandom_range(0, 49) == 0)});
      left -= len;
    end
  endfunction

  function automatic logic [63:0] random_small_reg();
    return {$urandom_range(0, 1) ? 14'd0 : 14'($urandom), 18'($urandom), $urandom};
  endfunction

  task automatic random_registers(input logic [9:0] junc);
    write_register(REG_TS, random_small_reg());
    write_register(REG_DX, random_small_reg());
    write_register(REG_DONOR, random_small_reg());
    write_register(REG_ACC, random_small_reg());
    write_register(REG_JUNC, {54'd0, junc});
  endtask

  initial begin
    step_scale = 63'd28147497671066;
    spacing    = 63'd562949953421;
    donor      = 63'd28147497671;
    acceptor   = 63'd28147497671;
    junction   = 10'd250;
    seen = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, single-position rows, a short clean row
    enqueue_sample('{S64_MAX, S64_MAX, 1'b1});
    enqueue_sample('{S64_MIN, S64_MIN, 1'b1});
    enqueue_sample('{S64_MAX, S64_MIN, 1'b0});
    enqueue_sample('{S64_MIN, S64_MAX, 1'b0});
    enqueue_sample('{64'sd0, -64'sd1, 1'b0});
    enqueue_sample('{-64'sd1, 64'sd0, 1'b1});
    for (int i = 0; i < 8; i++)
      enqueue_sample('{ONE_Q48 * (i + 1), ONE_Q48 * (8 - i), i == 7});
    enqueue_sample('{ONE_Q48, -ONE_Q48, 1'b1});
    enqueue_sample('{64'sd0, 64'sd0, 1'b1});
    drain();

    // clean register values, sender gaps
    random_registers(10'd6);
    send_idle_pct = 68;
    queue_rows(25);
    drain();

    // junction at zero, receiver stalls after a long hold-off
    random_registers(10'd0);
    send_idle_pct  = 0;
    recv_stall_pct = 68;
    fork
      begin
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    queue_rows(25);
    drain();

    // registers at their maximum but the junction at 512, both sides idle
    write_register(REG_TS, S64_MAX);
    write_register(REG_DX, S64_MAX);
    write_register(REG_DONOR, S64_MAX);
    write_register(REG_ACC, S64_MAX);
    write_register(REG_JUNC, 64'd512);
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    queue_rows(15);
    drain();

    // all zero, unused indexes ignored, a row running past the grid size
    write_register(REG_TS, '0);
    write_register(REG_DX, '0);
    write_register(REG_DONOR, '0);
    write_register(REG_ACC, '0);
    write_register(REG_JUNC, '0);
    write_register(3'd5, '1);
    write_register(3'd6, '1);
    write_register(3'd7, '1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < POSITIONS + 1; i++)
      enqueue_sample('{random_density(), random_density(), i == POSITIONS});
    drain();

    random_registers(10'($urandom_range(1, 512)));
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    queue_rows(25);
    drain();

    $display("checked %0d positions over %0d rows", results_checked, rows_done);
    $display("six register settings incl. extremes, idle and stall mixes, long hold-off");
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
